/* design/udm_pkg.sv */
package udm_pkg;

  localparam int DIVIDEND_BITS_DEF = 31;

  localparam int DIV_W   = 31;  // divisor width
  localparam int MULT_W  = 32;  // magic multiplier width
  localparam int SHIFT_W = 6;   // shift amount width
  localparam int LEN_W   = 5;   // bit length of the largest dividend
  localparam int PROD_W  = 63;  // nc * mod and 2^s + mod
  localparam int DIGIT_W = 8;   // multiplier digit per cycle
  localparam int NDIGITS = MULT_W / DIGIT_W;
  localparam int CNT_W   = 6;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  localparam logic [SHIFT_W-1:0] SHIFT_NONE = '1;
  localparam logic [MULT_W-1:0]  MULT_NONE  = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NCDIV,
    ST_INIT,
    ST_SETUP,
    ST_MUL,
    ST_CHECK,
    ST_MDIV,
    ST_FIN
  } state_t;

endpackage

/* design/unsigned_division_magic_number.sv */
// Finds a magic multiplier m and shift s so that n / d == (n * m) >> s for every
// n up to the largest dividend. One item is worked at a time and in_tready is
// high only while the block is free. A divisor of one or zero goes straight to
// the result. Otherwise the search tries shifts from zero up to 2 * bitlen(nmax).
// The work is done by a bit-per-cycle restoring divider that forms (nmax + 1)
// mod d first and the quotient (2^s + mod) / d last, and by a 31 x 8 digit
// multiplier that builds each trial product nc * mod digit by digit. The result
// sits in an output register, so the next item is taken while it waits. The found
// flag travels on out_tuser; when it is low the multiplier is all ones and the
// shift is 63.
module unsigned_division_magic_number #(
  parameter int DIVIDEND_BITS = udm_pkg::DIVIDEND_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [30:0] max_dividend, [61:31] divisor, [63:62] zero
  input  logic [udm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [31:0] multiplier, [37:32] shift_amount, [39:38] zero
  output logic [udm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] found
  output logic                               out_tuser
);

  localparam int DB  = DIVIDEND_BITS;
  localparam int PW  = udm_pkg::PROD_W;
  localparam int DW  = udm_pkg::DIV_W;
  localparam int MW  = udm_pkg::MULT_W;
  localparam int SW  = udm_pkg::SHIFT_W;
  localparam int LW  = udm_pkg::LEN_W;
  localparam int GW  = udm_pkg::DIGIT_W;
  localparam int CW  = udm_pkg::CNT_W;
  localparam int PAD = PW - (DB + 1);

  udm_pkg::state_t state_r, state_nxt;

  logic [DB-1:0]  nmax_r;
  logic [DB-1:0]  scan_r;
  logic [DW-1:0]  d_r;
  logic [CW-1:0]  cnt_r;
  logic [LW-1:0]  len_r;
  logic           len_set_r;
  logic [MW-1:0]  rem_r;
  logic [PW-1:0]  dv_r;
  logic [MW-1:0]  nc_r;
  logic [MW-1:0]  ncw_r;
  logic [DW-1:0]  r_r;
  logic [DW-1:0]  mod_r;
  logic [PW-1:0]  p_r;
  logic [PW-1:0]  acc_r;
  logic [SW-1:0]  s_r;
  logic [MW-1:0]  q_r;
  logic [MW-1:0]  m_r;
  logic           f_r;

  logic           out_tvalid_r;
  logic [MW-1:0]  out_m_r;
  logic [SW-1:0]  out_s_r;
  logic           out_f_r;

  logic           in_acc;
  logic           out_load;
  logic [DW-1:0]  in_nmax_w;
  logic [DW-1:0]  in_d;
  logic [DB:0]    np1;
  logic [MW-1:0]  div_t;
  logic           div_ge;
  logic [MW-1:0]  div_rem;
  logic [MW-1:0]  r2;
  logic           r2_ge;
  logic [SW-1:0]  limit;
  logic [DW+GW-1:0] prod;

  assign in_nmax_w = in_tdata[DW-1:0];
  assign in_d      = in_tdata[2*DW-1:DW];
  assign np1       = {1'b0, in_nmax_w[DB-1:0]} + (DB+1)'(1);

  // shared restoring divider step
  assign div_t   = {rem_r[MW-2:0], dv_r[PW-1]};
  assign div_ge  = div_t >= {1'b0, d_r};
  assign div_rem = div_ge ? div_t - {1'b0, d_r} : div_t;

  // (2^(s+1) - 1) mod d from (2^s - 1) mod d
  assign r2    = {r_r, 1'b1};
  assign r2_ge = r2 >= {1'b0, d_r};

  assign limit = {len_r, 1'b1};
  assign prod  = (DW+GW)'(mod_r) * (DW+GW)'(ncw_r[MW-1 -: GW]);

  assign in_tready = (state_r == udm_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == udm_pkg::ST_FIN) && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= udm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      udm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_d == DW'(1) || in_d == '0) begin
            state_nxt = udm_pkg::ST_FIN;
          end else begin
            state_nxt = udm_pkg::ST_NCDIV;
          end
        end
      end
      udm_pkg::ST_NCDIV: begin
        if (cnt_r == CW'(DB)) begin
          state_nxt = udm_pkg::ST_INIT;
        end
      end
      udm_pkg::ST_INIT: state_nxt = udm_pkg::ST_SETUP;
      udm_pkg::ST_SETUP: begin
        if (s_r < limit) begin
          state_nxt = udm_pkg::ST_MUL;
        end else begin
          state_nxt = udm_pkg::ST_FIN;
        end
      end
      udm_pkg::ST_MUL: begin
        if (cnt_r == CW'(udm_pkg::NDIGITS - 1)) begin
          state_nxt = udm_pkg::ST_CHECK;
        end
      end
      udm_pkg::ST_CHECK: begin
        if (p_r > acc_r) begin
          state_nxt = udm_pkg::ST_MDIV;
        end else begin
          state_nxt = udm_pkg::ST_SETUP;
        end
      end
      udm_pkg::ST_MDIV: begin
        if (cnt_r == CW'(PW - 1)) begin
          state_nxt = udm_pkg::ST_FIN;
        end
      end
      udm_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = udm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = udm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      udm_pkg::ST_IDLE: begin
        nmax_r    <= in_nmax_w[DB-1:0];
        scan_r    <= in_nmax_w[DB-1:0];
        d_r       <= in_d;
        dv_r      <= {np1, PAD'(0)};
        rem_r     <= '0;
        cnt_r     <= '0;
        len_r     <= '0;
        len_set_r <= 1'b0;
        if (in_d == DW'(1)) begin
          m_r <= MW'(1);
          s_r <= '0;
          f_r <= 1'b1;
        end else begin
          m_r <= udm_pkg::MULT_NONE;
          s_r <= udm_pkg::SHIFT_NONE;
          f_r <= 1'b0;
        end
      end
      udm_pkg::ST_NCDIV: begin
        rem_r  <= div_rem;
        dv_r   <= {dv_r[PW-2:0], 1'b0};
        scan_r <= {scan_r[DB-2:0], 1'b0};
        cnt_r  <= cnt_r + CW'(1);
        // first one seen from the top sets the bit length
        if (!len_set_r && scan_r[DB-1] && cnt_r < CW'(DB)) begin
          len_r     <= LW'(DB) - cnt_r[LW-1:0];
          len_set_r <= 1'b1;
        end
      end
      udm_pkg::ST_INIT: begin
        nc_r <= MW'(nmax_r) - rem_r;
        r_r  <= '0;
        p_r  <= PW'(1);
        s_r  <= '0;
      end
      udm_pkg::ST_SETUP: begin
        mod_r <= d_r - DW'(1) - r_r;
        ncw_r <= nc_r;
        acc_r <= '0;
        cnt_r <= '0;
        if (s_r >= limit) begin
          s_r <= udm_pkg::SHIFT_NONE;
        end
      end
      udm_pkg::ST_MUL: begin
        acc_r <= {acc_r[PW-GW-1:0], GW'(0)} + PW'(prod);
        ncw_r <= {ncw_r[MW-GW-1:0], GW'(0)};
        cnt_r <= cnt_r + CW'(1);
      end
      udm_pkg::ST_CHECK: begin
        if (p_r > acc_r) begin
          dv_r  <= p_r + PW'(mod_r);
          rem_r <= '0;
          q_r   <= '0;
          cnt_r <= '0;
        end else begin
          r_r <= r2_ge ? DW'(r2 - {1'b0, d_r}) : DW'(r2);
          p_r <= {p_r[PW-2:0], 1'b0};
          s_r <= s_r + SW'(1);
        end
      end
      udm_pkg::ST_MDIV: begin
        rem_r <= div_rem;
        dv_r  <= {dv_r[PW-2:0], 1'b0};
        q_r   <= {q_r[MW-2:0], div_ge};
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(PW - 1)) begin
          m_r <= {q_r[MW-2:0], div_ge};
          f_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_m_r <= m_r;
      out_s_r <= s_r;
      out_f_r <= f_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(udm_pkg::OUT_TDATA_W - MW - SW)'(0), out_s_r, out_m_r};
  assign out_tuser  = out_f_r;

  // remainder of the shared divider stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == udm_pkg::ST_INIT || state_r == udm_pkg::ST_FIN) && f_r == 1'b0
      && d_r != '0 && d_r != DW'(1) |-> rem_r < {1'b0, d_r})
    else $error("divider remainder not below divisor");

  // running (2^s - 1) mod d stays reduced
  a_r_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == udm_pkg::ST_SETUP |-> r_r < d_r)
    else $error("power remainder not reduced");

  // a not-found result carries the marker pattern
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[MW+SW-1:MW] == udm_pkg::SHIFT_NONE && out_tdata[MW-1:0] == udm_pkg::MULT_NONE)
    else $error("not-found result without marker");

  // a found shift never reaches the marker value
  a_found_shift: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[MW+SW-1:MW] != udm_pkg::SHIFT_NONE)
    else $error("found result with marker shift");

  // a new result is only loaded once the previous one has left
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_tvalid_r || out_tready)
    else $error("pending result overwritten");

endmodule

/* test/tb.sv */
typedef struct {
  logic [30:0] nmax;
  logic [30:0] divisor;
  logic [31:0] mult;
  logic [5:0]  shift;
  logic        found;
} magic_t;

class magic_scoreboard;
  magic_t expected_q[$];
  int unsigned errors;
  int unsigned results;

  function new();
    errors = 0;
    results = 0;
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // search shifts from zero up to twice the bit length of nmax
  function magic_t predict_magic(logic [30:0] nmax, logic [30:0] d);
    magic_t r;
    logic [31:0] quo32;
    logic [31:0] nc32;
    logic [63:0] nc;
    logic [63:0] p;
    logic [63:0] md;
    logic [63:0] d64;
    logic [63:0] m64;
    int unsigned blen;
    int unsigned lim;
    bit hit;
    r.nmax = nmax;
    r.divisor = d;
    r.mult = '1;
    r.shift = '1;
    r.found = 1'b0;
    if (d == 31'd1) begin
      r.mult = 32'd1;
      r.shift = 6'd0;
      r.found = 1'b1;
    end else if (d != 31'd0) begin
      d64 = {33'd0, d};
      quo32 = ({1'b0, nmax} + 32'd1) / {1'b0, d};
      // wraps to all ones when nmax + 1 is below d
      nc32 = quo32 * {1'b0, d} - 32'd1;
      nc = {32'd0, nc32};
      blen = 0;
      for (int i = 0; i < 31; i++) if (nmax[i]) blen = i + 1;
      lim = 2 * blen + 1;
      hit = 1'b0;
      for (int s = 0; s < lim && s < 63 && !hit; s++) begin
        p = 64'd1 << s;
        md = d64 - 64'd1 - ((p - 64'd1) % d64);
        if (p > nc * md) begin
          m64 = (p + md) / d64;
          r.mult = m64[31:0];
          r.shift = s[5:0];
          r.found = 1'b1;
          hit = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task note_input(logic [30:0] nmax, logic [30:0] d);
    expected_q.push_back(predict_magic(nmax, d));
  endtask

  task check_result(logic [31:0] mult, logic [5:0] shift, logic found);
    magic_t want;
    results++;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected item m=%h s=%0d f=%b", mult, shift, found));
    end else begin
      want = expected_q.pop_front();
      if (mult !== want.mult)
        report($sformatf("nmax=%0d d=%0d multiplier %h, want %h",
                         want.nmax, want.divisor, mult, want.mult));
      if (shift !== want.shift)
        report($sformatf("nmax=%0d d=%0d shift %0d, want %0d",
                         want.nmax, want.divisor, shift, want.shift));
      if (found !== want.found)
        report($sformatf("nmax=%0d d=%0d found %b, want %b",
                         want.nmax, want.divisor, found, want.found));
    end
  endtask
endclass

module tb;

  localparam int RAND_ITEMS = 1400;
  localparam int CALM_FROM  = RAND_ITEMS - 150;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [udm_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [udm_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tuser;

  bit calm = 1'b0;
  magic_scoreboard board = new();

  always #2 clk = ~clk;

  unsigned_division_magic_number i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // random value of exactly len bits (top bit set), zero for len 0
  function automatic logic [30:0] rand_len(int unsigned len);
    logic [31:0] v;
    v = '0;
    if (len != 0) begin
      v = $urandom & (32'hFFFF_FFFF >> (32 - len));
      v[len-1] = 1'b1;
    end
    return v[30:0];
  endfunction

  function automatic int unsigned bit_len(logic [30:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 31; i++) if (v[i]) n = i + 1;
    return n;
  endfunction

  task automatic send_magic(logic [30:0] nmax, logic [30:0] d);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= {$urandom, $urandom};
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, d, nmax};
    do @(posedge clk); while (!in_tready);
    board.note_input(nmax, d);
  endtask

  // result side: random stalls plus one long hold-off to back up the input
  initial begin : sink
    int unsigned stall;
    bit held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        board.check_result(out_tdata[udm_pkg::MULT_W-1:0],
                           out_tdata[udm_pkg::MULT_W +: udm_pkg::SHIFT_W], out_tuser);
      if (!held && board.results == 150) begin
        held = 1'b1;
        stall = 1500;
      end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : source
    logic [30:0] nmax;
    logic [30:0] d;
    int unsigned len;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_magic(31'd0, 31'd1);
    send_magic('1, 31'd1);
    send_magic(31'd0, 31'd0);
    send_magic('1, 31'd0);
    send_magic(31'd0, 31'd2);
    send_magic(31'd0, '1);
    send_magic('1, '1);
    send_magic('1, 31'd2);
    send_magic('1, 31'd3);
    send_magic('1, 31'd7);
    send_magic('1, 31'd641);
    send_magic('1, 31'h4000_0000);
    send_magic(31'd5, 31'd100);
    send_magic(31'd1, 31'd3);
    send_magic(31'd1, 31'd2);
    send_magic(31'd1, 31'd1);
    send_magic(31'd9, 31'd10);
    send_magic(31'd10, 31'd10);
    send_magic(31'd255, 31'd3);
    send_magic(31'd65535, 31'd10);
    send_magic(31'd1000000, 31'd7);
    send_magic(31'h4000_0000, 31'd12345);

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k >= CALM_FROM) calm = 1'b1;
      len = ($urandom_range(0, 1) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 31);
      nmax = rand_len(len);
      case ($urandom_range(0, 15))
        0: d = 31'd1;
        1, 2: d = 31'($urandom_range(2, 16));
        3: d = ($urandom_range(0, 3) == 0) ? 31'd0 : rand_len($urandom_range(1, 31));
        4, 5, 6, 7, 8, 9: begin
          // keep d near or below nmax so that most searches succeed
          len = bit_len(nmax) + 1;
          if (len > 31) len = 31;
          d = rand_len($urandom_range(1, len));
        end
        default: d = rand_len($urandom_range(1, 31));
      endcase
      send_magic(nmax, d);
    end

    in_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #15000000;
    $display("FAILURE");
    $finish;
  end
endmodule
